[hdl/dtu_pkg.sv]
// Shared types, constants and helpers for the divider and timer unit.
// No dependencies; used by dtu_ctrl, dtu_dp and divider_and_timer_unit.
`timescale 1ns / 1ps

package dtu_pkg;

  // Clamp applied to the cycle count of each input beat.
  localparam int MAX_CYCLES_PER_ITEM = 255;

  // Widths of the stored state and the working values.
  localparam int CYC_W   = 8;   // cycles_elapsed
  localparam int CNT_W   = 8;   // divider and timer counts
  localparam int TREM_W  = 10;  // timer remainder, below the longest period
  localparam int TSUM_W  = 11;  // timer remainder plus cycles
  localparam int TICK_W  = 7;   // timer steps owed by one beat
  localparam int OVF_W   = 5;   // overflow count
  localparam int SHIFT_W = 4;   // log2 of the timer period

  // Timer steps applied per cycle by the step logic.
  localparam int STEPS_PER_CYCLE = 4;
  localparam int STEP_N_W        = 3;

  localparam logic [OVF_W-1:0] OVF_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
  localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [1:0] REG_TIMER_RELOAD = 2'd2;

  // Clock select codes.
  localparam logic [1:0] CSEL_1024 = 2'd0;
  localparam logic [1:0] CSEL_16   = 2'd1;
  localparam logic [1:0] CSEL_64   = 2'd2;
  localparam logic [1:0] CSEL_256  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;     // take the input beat, update divider, compute timer steps
    logic step;     // apply up to STEPS_PER_CYCLE timer steps
    logic publish;  // copy the counts into the output register
  } cmd_t;

  typedef struct packed {
    logic last_step;  // the owed steps fit into the current cycle
  } status_t;

  // log2 of the timer period for a clock select code.
  function automatic logic [SHIFT_W-1:0] period_shift(input logic [1:0] sel);
    logic [SHIFT_W-1:0] sh;
    unique case (sel)
      CSEL_1024: sh = 4'd10;
      CSEL_16:   sh = 4'd4;
      CSEL_64:   sh = 4'd6;
      CSEL_256:  sh = 4'd8;
      default:   sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

[hdl/dtu_ctrl.sv]
// Controller of the divider and timer unit: handshakes and sequencing.
// Depends on dtu_pkg; drives dtu_dp through a command struct.
`timescale 1ns / 1ps

module dtu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dtu_pkg::status_t status,
  output dtu_pkg::cmd_t    cmd
);

  dtu_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      dtu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dtu_pkg::ST_STEP;
        end
      end
      dtu_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_nxt = dtu_pkg::ST_PUSH;
        end
      end
      dtu_pkg::ST_PUSH: begin
        // The output register is free when empty or when its beat leaves now.
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = dtu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtu_pkg::ST_IDLE;
    endcase

    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/dtu_dp.sv]
// Datapath of the divider and timer unit: counters, remainders, step logic
// and the output register. Depends on dtu_pkg; controlled by dtu_ctrl.
`timescale 1ns / 1ps

module dtu_dp #(
  parameter int MAX_CYCLES_PER_ITEM = dtu_pkg::MAX_CYCLES_PER_ITEM
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dtu_pkg::cmd_t               cmd,
  output dtu_pkg::status_t            status,
  input  logic [dtu_pkg::CYC_W-1:0]   cycles_elapsed,
  input  logic                        timer_enable,
  input  logic [1:0]                  clock_select,
  input  logic [dtu_pkg::CNT_W-1:0]   timer_reload,
  output logic [dtu_pkg::CNT_W-1:0]   divider_value,
  output logic [dtu_pkg::CNT_W-1:0]   timer_value,
  output logic [dtu_pkg::OVF_W-1:0]   overflow_count,
  output logic                        timer_irq
);

  logic [dtu_pkg::CNT_W-1:0]  div_count_r, div_count_nxt;
  logic [dtu_pkg::CNT_W-1:0]  div_rem_r, div_rem_nxt;
  logic [dtu_pkg::CNT_W-1:0]  tmr_count_r, tmr_count_nxt;
  logic [dtu_pkg::TREM_W-1:0] tmr_rem_r, tmr_rem_nxt;
  logic [dtu_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic [dtu_pkg::OVF_W-1:0]  ovf_r, ovf_nxt;

  logic [dtu_pkg::CNT_W-1:0]  out_div_r;
  logic [dtu_pkg::CNT_W-1:0]  out_tmr_r;
  logic [dtu_pkg::OVF_W-1:0]  out_ovf_r;
  logic                       out_irq_r;

  logic [dtu_pkg::CYC_W-1:0]   cyc;
  logic [dtu_pkg::CNT_W:0]     div_sum;
  logic [dtu_pkg::SHIFT_W-1:0] shift;
  logic [dtu_pkg::TSUM_W-1:0]  mask;
  logic [dtu_pkg::TSUM_W-1:0]  tmr_sum;
  logic [dtu_pkg::STEP_N_W-1:0] step_n;
  logic [dtu_pkg::CNT_W-1:0]   step_cnt;
  logic [dtu_pkg::OVF_W-1:0]   step_ovf;

  // Clamp, divider sum and timer sum for the beat being taken.
  always_comb begin
    if ({{(dtu_pkg::TSUM_W-dtu_pkg::CYC_W){1'b0}}, cycles_elapsed} >
        dtu_pkg::TSUM_W'(MAX_CYCLES_PER_ITEM)) begin
      cyc = dtu_pkg::CYC_W'(MAX_CYCLES_PER_ITEM);
    end else begin
      cyc = cycles_elapsed;
    end
    div_sum = {1'b0, div_rem_r} + {1'b0, cyc};
    shift   = dtu_pkg::period_shift(clock_select);
    mask    = (dtu_pkg::TSUM_W'(1) << shift) - dtu_pkg::TSUM_W'(1);
    tmr_sum = (dtu_pkg::TSUM_W'(tmr_rem_r) & mask) + dtu_pkg::TSUM_W'(cyc);
  end

  // Up to four dependent timer steps per cycle.
  always_comb begin
    if (ticks_r > dtu_pkg::TICK_W'(dtu_pkg::STEPS_PER_CYCLE)) begin
      step_n = dtu_pkg::STEP_N_W'(dtu_pkg::STEPS_PER_CYCLE);
    end else begin
      step_n = ticks_r[dtu_pkg::STEP_N_W-1:0];
    end
    step_cnt = tmr_count_r;
    step_ovf = ovf_r;
    for (int i = 0; i < dtu_pkg::STEPS_PER_CYCLE; i++) begin
      if (dtu_pkg::STEP_N_W'(i) < step_n) begin
        if (step_cnt == dtu_pkg::CNT_TOP) begin
          step_cnt = timer_reload;
          if (step_ovf != dtu_pkg::OVF_MAX) begin
            step_ovf = step_ovf + dtu_pkg::OVF_W'(1);
          end
        end else begin
          step_cnt = step_cnt + dtu_pkg::CNT_W'(1);
        end
      end
    end
    status.last_step = (ticks_r <= dtu_pkg::TICK_W'(dtu_pkg::STEPS_PER_CYCLE));
  end

  always_comb begin
    div_count_nxt = div_count_r;
    div_rem_nxt   = div_rem_r;
    tmr_count_nxt = tmr_count_r;
    tmr_rem_nxt   = tmr_rem_r;
    ticks_nxt     = ticks_r;
    ovf_nxt       = ovf_r;
    if (cmd.load) begin
      div_count_nxt = div_count_r + dtu_pkg::CNT_W'(div_sum[dtu_pkg::CNT_W]);
      div_rem_nxt   = div_sum[dtu_pkg::CNT_W-1:0];
      ovf_nxt       = '0;
      if (timer_enable) begin
        ticks_nxt   = dtu_pkg::TICK_W'(tmr_sum >> shift);
        tmr_rem_nxt = dtu_pkg::TREM_W'(tmr_sum & mask);
      end else begin
        ticks_nxt   = '0;
      end
    end else if (cmd.step) begin
      tmr_count_nxt = step_cnt;
      ovf_nxt       = step_ovf;
      ticks_nxt     = ticks_r - dtu_pkg::TICK_W'(step_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_count_r <= '0;
      div_rem_r   <= '0;
      tmr_count_r <= '0;
      tmr_rem_r   <= '0;
      ticks_r     <= '0;
      ovf_r       <= '0;
    end else begin
      div_count_r <= div_count_nxt;
      div_rem_r   <= div_rem_nxt;
      tmr_count_r <= tmr_count_nxt;
      tmr_rem_r   <= tmr_rem_nxt;
      ticks_r     <= ticks_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Output register; valid is kept by the controller.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_div_r <= div_count_r;
      out_tmr_r <= tmr_count_r;
      out_ovf_r <= ovf_r;
      out_irq_r <= (ovf_r != '0);
    end
  end

  assign divider_value  = out_div_r;
  assign timer_value    = out_tmr_r;
  assign overflow_count = out_ovf_r;
  assign timer_irq      = out_irq_r;

endmodule

[hdl/divider_and_timer_unit.sv]
// Top level of the divider and timer unit: configuration registers and the
// controller and datapath. Depends on dtu_pkg, dtu_ctrl and dtu_dp.
`timescale 1ns / 1ps

// How the block is used:
// Each input beat carries in_cycles_elapsed, the CPU time passed since the
// previous beat. For each input beat exactly one output beat follows with the
// free-running divider count, the timer count, the number of timer overflows
// caused by this beat and the timer interrupt request.
// Both channels use valid and ready. The configuration port is a plain write
// port (cfg_we, cfg_index, cfg_wdata); index 0 is the timer enable, 1 the
// clock select and 2 the reload value. Other indexes are ignored.
// Each beat is taken in the idle state of the controller and then passes
// through the step and push states in that order; the step state repeats until the owed timer steps are done.
// A beat owes at most 16 timer steps for an 8-bit cycle count at the fastest
// clock select. The timer step logic applies up to four steps per cycle. One
// beat is in work at a time; no new beat is taken before it is published.
// A finished result sits in an output register; the next input beat is taken
// while it waits. If the receiver stalls, the following result waits in the
// datapath and no further input beat is accepted until it moves out.
// Synchronous reset clears all counters, remainders and configuration
// registers to zero and leaves both channels empty; output data is not reset.

module divider_and_timer_unit #(
  parameter int MAX_CYCLES_PER_ITEM = dtu_pkg::MAX_CYCLES_PER_ITEM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dtu_pkg::CYC_W-1:0]         in_cycles_elapsed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtu_pkg::CNT_W-1:0]         out_divider_value,
  output logic [dtu_pkg::CNT_W-1:0]         out_timer_value,
  output logic [dtu_pkg::OVF_W-1:0]         out_overflow_count,
  output logic                              out_timer_irq,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dtu_pkg::CNT_W-1:0]         cfg_wdata
);

  logic                      timer_enable_r;
  logic [1:0]                clock_select_r;
  logic [dtu_pkg::CNT_W-1:0] timer_reload_r;

  dtu_pkg::cmd_t    cmd;
  dtu_pkg::status_t status;

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_enable_r <= 1'b0;
      clock_select_r <= dtu_pkg::CSEL_1024;
      timer_reload_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtu_pkg::REG_TIMER_ENABLE: timer_enable_r <= cfg_wdata[0];
        dtu_pkg::REG_CLOCK_SELECT: clock_select_r <= cfg_wdata[1:0];
        dtu_pkg::REG_TIMER_RELOAD: timer_reload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtu_dp #(
    .MAX_CYCLES_PER_ITEM (MAX_CYCLES_PER_ITEM)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cycles_elapsed (in_cycles_elapsed),
    .timer_enable   (timer_enable_r),
    .clock_select   (clock_select_r),
    .timer_reload   (timer_reload_r),
    .divider_value  (out_divider_value),
    .timer_value    (out_timer_value),
    .overflow_count (out_overflow_count),
    .timer_irq      (out_timer_irq)
  );

endmodule
